FILE: sv/rmq_pkg.sv
// Shared types, widths and codes of the rotation matrix to quaternion block.
`timescale 1ns / 1ps
package rmq_pkg;

	// Element and unit vector formats.
	localparam int ELEM_W    = 32;
	localparam int UNIT_W    = 32;
	localparam int UNIT_FRAC = 30;
	localparam int NORM_W    = 30;
	localparam int NORM_POS  = 29;

	// Unit vector scaler internals.
	localparam int UV_SQ_W   = 60;
	localparam int UV_SUM_W  = 62;
	localparam int UV_LEN_W  = UV_SUM_W / 2;
	localparam int UV_NUM_W  = NORM_W + UNIT_FRAC;
	localparam int UV_QW     = 31;
	localparam int UV_LAT    = 5 + UV_SUM_W / 2 + UV_QW + 1;

	// Quaternion extraction widths.
	localparam int ROW_N     = 3;
	localparam int QUAT_N    = 4;
	localparam int T_W       = 34;
	localparam int D_W       = 33;
	localparam int DMAG_W    = 32;
	localparam int RAD_W     = 64;
	localparam int ROOT_W    = RAD_W / 2;
	localparam int QD_NUM_W  = DMAG_W + UNIT_FRAC;
	localparam int QD_QW     = 47;
	localparam int PRE_W     = 48;

	// Total latency from an accepted request to its result.
	localparam int LAT = 2 * UV_LAT + 2 + RAD_W / 2 + QD_QW + 1;

	localparam logic signed [T_W-1:0] T_ONE   = T_W'(1) <<< UNIT_FRAC;
	localparam logic signed [T_W-1:0] T_MIN   = T_W'(1);
	localparam logic signed [T_W-1:0] T_ZERO  = '0;
	localparam logic signed [UNIT_W-1:0] Q_MAX = UNIT_W'(1) <<< UNIT_FRAC;

	// Branch codes.
	localparam logic [1:0] BR_TRACE = 2'd0;
	localparam logic [1:0] BR_X     = 2'd1;
	localparam logic [1:0] BR_Y     = 2'd2;
	localparam logic [1:0] BR_Z     = 2'd3;

	typedef struct packed {
		logic signed [ELEM_W-1:0] r0_x;
		logic signed [ELEM_W-1:0] r0_y;
		logic signed [ELEM_W-1:0] r0_z;
		logic signed [ELEM_W-1:0] r1_x;
		logic signed [ELEM_W-1:0] r1_y;
		logic signed [ELEM_W-1:0] r1_z;
		logic signed [ELEM_W-1:0] r2_x;
		logic signed [ELEM_W-1:0] r2_y;
		logic signed [ELEM_W-1:0] r2_z;
	} mat_t;

	typedef struct packed {
		logic signed [UNIT_W-1:0] quat_x;
		logic signed [UNIT_W-1:0] quat_y;
		logic signed [UNIT_W-1:0] quat_z;
		logic signed [UNIT_W-1:0] quat_w;
		logic [1:0]               branch_taken;
	} quat_t;

endpackage

FILE: sv/rmq_stream_if.sv
// Valid/ready stream interface carrying one request payload.
`timescale 1ns / 1ps
interface rmq_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: sv/rotation_matrix_to_quaternion_top.sv
// Top level: rotation matrix rows in Q16.16 to a unit quaternion in Q2.30.
`timescale 1ns / 1ps
// This block takes one 3x3 rotation matrix per request on the mat channel, three rows of
// signed Q16.16, and returns one unit quaternion x, y, z, w in signed Q2.30 together with
// the branch of the trace-or-largest-diagonal method that produced it on the quat channel.
// Every row is first scaled to unit length (an all-zero row becomes a zero vector), the
// radicand of the chosen branch goes through a square root, the three remaining terms are
// divided by that root, and the quaternion is scaled to unit length at the end. The block
// accepts a new request in every cycle unless the pipeline is held, and returns one result
// per request in order. Each of the two unit-length scalers is mostly a 31-stage square
// root and a 31-stage divider, and the quaternion core adds a 32-stage square root and a
// 47-stage divider plus three register stages. The whole pipeline advances together and
// holds while a finished result waits on quat.
module rotation_matrix_to_quaternion_top (
	input  logic                clk,
	input  logic                arst_n,
	rmq_stream_if.sink          mat,
	rmq_stream_if.source        quat
);
	import rmq_pkg::*;

	localparam int SIDE_A = ROW_N * DMAG_W + ROW_N + 2;
	localparam int SIDE_B = ROOT_W + ROW_N + 2;

	logic                                    pipe_en;
	logic [LAT-1:0]                          vld_q;
	logic [ROW_N-1:0][ROW_N-1:0][UNIT_W-1:0] urow;
	logic [ROW_N-1:0][ROW_N-1:0][UNIT_W-1:0] rm_s1;
	logic signed [T_W-1:0]                   s_s1;
	logic                                    gtx_s1;
	logic                                    gty_s1;
	logic signed [UNIT_W-1:0]                e [ROW_N][ROW_N];
	logic [1:0]                              br_c;
	logic signed [T_W-1:0]                   t_raw;
	logic signed [T_W-1:0]                   t_c;
	logic signed [D_W-1:0]                   d_c [ROW_N];
	logic [RAD_W-1:0]                        rad_s2;
	logic [ROW_N-1:0][DMAG_W-1:0]            dmag_s2;
	logic [ROW_N-1:0]                        dneg_s2;
	logic [1:0]                              br_s2;
	logic [ROOT_W-1:0]                       root;
	logic [ROW_N-1:0][DMAG_W-1:0]            dmag_a;
	logic [ROW_N-1:0]                        dneg_a;
	logic [1:0]                              br_a;
	logic [ROW_N-1:0][QD_QW-1:0]             quo;
	logic [ROOT_W-1:0]                       root_b;
	logic [ROW_N-1:0]                        dneg_b;
	logic [1:0]                              br_b;
	logic signed [PRE_W-1:0]                 qs [ROW_N];
	logic signed [PRE_W-1:0]                 rootp;
	logic [QUAT_N-1:0][PRE_W-1:0]            pre_c;
	logic [QUAT_N-1:0][PRE_W-1:0]            pre_s3;
	logic [1:0]                              br_s3;
	logic [QUAT_N-1:0][UNIT_W-1:0]           qv;
	logic [1:0]                              br_out;

	// The whole pipeline moves unless a finished result is waiting on quat.
	assign pipe_en   = !quat.valid || quat.ready;
	assign mat.ready = pipe_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (pipe_en) begin
			vld_q <= {vld_q[LAT-2:0], mat.valid};
		end
	end

	assign quat.valid = vld_q[LAT-1];

	// Row scaling: element 0 of each vector is the x column.
	rmq_unit_vec #(.N(ROW_N), .VW(ELEM_W)) u_row0 (
		.clk (clk),
		.en  (pipe_en),
		.v   ({mat.data.r0_z, mat.data.r0_y, mat.data.r0_x}),
		.o   (urow[0])
	);

	rmq_unit_vec #(.N(ROW_N), .VW(ELEM_W)) u_row1 (
		.clk (clk),
		.en  (pipe_en),
		.v   ({mat.data.r1_z, mat.data.r1_y, mat.data.r1_x}),
		.o   (urow[1])
	);

	rmq_unit_vec #(.N(ROW_N), .VW(ELEM_W)) u_row2 (
		.clk (clk),
		.en  (pipe_en),
		.v   ({mat.data.r2_z, mat.data.r2_y, mat.data.r2_x}),
		.o   (urow[2])
	);

	// One plus the trace and the diagonal comparisons are taken first.
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			rm_s1  <= urow;
			s_s1   <= T_W'($signed(urow[0][0])) + T_W'($signed(urow[1][1]))
			        + T_W'($signed(urow[2][2])) + T_ONE;
			gtx_s1 <= ($signed(urow[0][0]) > $signed(urow[1][1]))
			       && ($signed(urow[0][0]) > $signed(urow[2][2]));
			gty_s1 <= ($signed(urow[1][1]) > $signed(urow[2][2]));
		end
	end

	always_comb begin
		for (int i = 0; i < ROW_N; i++) begin
			for (int j = 0; j < ROW_N; j++) begin
				e[i][j] = $signed(rm_s1[i][j]);
			end
		end
	end

	// Branch selection, radicand and the three numerators. In the x, y and z branches w takes
	// the difference term that the trace branch gives to that axis.
	always_comb begin
		priority if (s_s1 > T_ZERO) begin
			br_c   = BR_TRACE;
			t_raw  = s_s1;
			d_c[0] = D_W'(e[1][2]) - D_W'(e[2][1]);
			d_c[1] = D_W'(e[2][0]) - D_W'(e[0][2]);
			d_c[2] = D_W'(e[0][1]) - D_W'(e[1][0]);
		end else if (gtx_s1) begin
			br_c   = BR_X;
			t_raw  = T_ONE + T_W'(e[0][0]) - T_W'(e[1][1]) - T_W'(e[2][2]);
			d_c[0] = D_W'(e[1][2]) - D_W'(e[2][1]);
			d_c[1] = D_W'(e[1][0]) + D_W'(e[0][1]);
			d_c[2] = D_W'(e[2][0]) + D_W'(e[0][2]);
		end else if (gty_s1) begin
			br_c   = BR_Y;
			t_raw  = T_ONE + T_W'(e[1][1]) - T_W'(e[0][0]) - T_W'(e[2][2]);
			d_c[0] = D_W'(e[2][0]) - D_W'(e[0][2]);
			d_c[1] = D_W'(e[1][0]) + D_W'(e[0][1]);
			d_c[2] = D_W'(e[2][1]) + D_W'(e[1][2]);
		end else begin
			br_c   = BR_Z;
			t_raw  = T_ONE + T_W'(e[2][2]) - T_W'(e[0][0]) - T_W'(e[1][1]);
			d_c[0] = D_W'(e[0][1]) - D_W'(e[1][0]);
			d_c[1] = D_W'(e[2][0]) + D_W'(e[0][2]);
			d_c[2] = D_W'(e[2][1]) + D_W'(e[1][2]);
		end
		// A radicand below one LSB is raised to one LSB so the root stays nonzero.
		t_c = (t_raw < T_MIN) ? T_MIN : t_raw;
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			rad_s2 <= RAD_W'(t_c[T_W-2:0]) << UNIT_FRAC;
			br_s2  <= br_c;
			for (int i = 0; i < ROW_N; i++) begin
				dneg_s2[i] <= d_c[i][D_W-1];
				dmag_s2[i] <= d_c[i][D_W-1] ? DMAG_W'(-d_c[i]) : DMAG_W'(d_c[i]);
			end
		end
	end

	rmq_isqrt #(.W(RAD_W)) u_root (
		.clk  (clk),
		.en   (pipe_en),
		.rad  (rad_s2),
		.root (root)
	);

	rmq_delay #(.W(SIDE_A), .D(RAD_W / 2)) u_side_a (
		.clk (clk),
		.en  (pipe_en),
		.d   ({dmag_s2, dneg_s2, br_s2}),
		.q   ({dmag_a, dneg_a, br_a})
	);

	for (genvar i = 0; i < ROW_N; i++) begin : g_div
		rmq_div #(.NW(QD_NUM_W), .DW(ROOT_W), .QW(QD_QW)) u_div (
			.clk (clk),
			.en  (pipe_en),
			.num ({dmag_a[i], {UNIT_FRAC{1'b0}}}),
			.den (root),
			.quo (quo[i])
		);
	end

	rmq_delay #(.W(SIDE_B), .D(QD_QW)) u_side_b (
		.clk (clk),
		.en  (pipe_en),
		.d   ({root, dneg_a, br_a}),
		.q   ({root_b, dneg_b, br_b})
	);

	// Place the root and the signed quotients into x, y, z, w (index 0 to 3).
	always_comb begin
		for (int i = 0; i < ROW_N; i++) begin
			qs[i] = dneg_b[i] ? ('0 - PRE_W'(quo[i])) : PRE_W'(quo[i]);
		end
		rootp = PRE_W'(root_b);
		unique case (br_b)
			BR_TRACE: pre_c = {rootp, qs[2], qs[1], qs[0]};
			BR_X:     pre_c = {qs[0], qs[2], qs[1], rootp};
			BR_Y:     pre_c = {qs[0], qs[2], rootp, qs[1]};
			default:  pre_c = {qs[0], rootp, qs[2], qs[1]};
		endcase
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			pre_s3 <= pre_c;
			br_s3  <= br_b;
		end
	end

	rmq_unit_vec #(.N(QUAT_N), .VW(PRE_W)) u_quat (
		.clk (clk),
		.en  (pipe_en),
		.v   (pre_s3),
		.o   (qv)
	);

	rmq_delay #(.W(2), .D(UV_LAT)) u_br (
		.clk (clk),
		.en  (pipe_en),
		.d   (br_s3),
		.q   (br_out)
	);

	assign quat.data.quat_x       = qv[0];
	assign quat.data.quat_y       = qv[1];
	assign quat.data.quat_z       = qv[2];
	assign quat.data.quat_w       = qv[3];
	assign quat.data.branch_taken = br_out;

	// A stalled pipeline neither drops nor duplicates requests in flight.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!pipe_en |=> $stable(vld_q))
		else $error("valid line moved during a stall");

	// Unit-length scaling never yields a component beyond one.
	a_xy_range: assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid |-> (quat.data.quat_x <= Q_MAX) && (quat.data.quat_x >= -Q_MAX)
		&& (quat.data.quat_y <= Q_MAX) && (quat.data.quat_y >= -Q_MAX))
		else $error("quaternion x or y out of range");

	a_zw_range: assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid |-> (quat.data.quat_z <= Q_MAX) && (quat.data.quat_z >= -Q_MAX)
		&& (quat.data.quat_w <= Q_MAX) && (quat.data.quat_w >= -Q_MAX))
		else $error("quaternion z or w out of range");
endmodule

FILE: sv/rmq_delay.sv
// Enabled delay line that keeps side data aligned with the arithmetic units.
`timescale 1ns / 1ps
module rmq_delay #(
	parameter int W = 1,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] line_q [D];

	always_ff @(posedge clk) begin
		if (en) begin
			line_q[0] <= d;
			for (int i = 1; i < D; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign q = line_q[D-1];
endmodule

FILE: sv/rmq_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module rmq_isqrt #(
	parameter int W = 64
) (
	input  logic           clk,
	input  logic           en,
	input  logic [W-1:0]   rad,
	output logic [W/2-1:0] root
);
	localparam int RW = W / 2;

	logic [RW+1:0] rem_s  [RW+1];
	logic [RW-1:0] root_s [RW+1];
	logic [W-1:0]  val_s  [RW+1];

	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign val_s[0]  = rad;

	for (genvar k = 0; k < RW; k++) begin : g_step
		logic [RW+1:0] cur;
		logic [RW+1:0] trial;
		logic          ge;

		// The remainder never exceeds twice the partial root, so its low bits suffice.
		assign cur   = {rem_s[k][RW-1:0], val_s[k][W-1 -: 2]};
		assign trial = {root_s[k], 2'b01};
		assign ge    = (cur >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? (cur - trial) : cur;
				root_s[k+1] <= {root_s[k][RW-2:0], ge};
				val_s[k+1]  <= val_s[k] << 2;
			end
		end
	end

	assign root = root_s[RW];
endmodule

FILE: sv/rmq_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module rmq_div #(
	parameter int NW = 60,
	parameter int DW = 31,
	parameter int QW = 31
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);
	logic [DW-1:0] rem_s [QW+1];
	logic [DW-1:0] den_s [QW+1];
	logic [QW-1:0] quo_s [QW+1];
	logic [QW-1:0] low_s [QW+1];

	// The quotient fits QW bits, so the upper numerator bits are already below the divisor.
	assign rem_s[0] = DW'(num[NW-1:QW]);
	assign den_s[0] = den;
	assign quo_s[0] = '0;
	assign low_s[0] = num[QW-1:0];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DW:0] cur;
		logic        ge;

		assign cur = {rem_s[k], low_s[k][QW-1]};
		assign ge  = (cur >= {1'b0, den_s[k]});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? DW'(cur - {1'b0, den_s[k]}) : cur[DW-1:0];
				den_s[k+1] <= den_s[k];
				quo_s[k+1] <= {quo_s[k][QW-2:0], ge};
				low_s[k+1] <= low_s[k] << 1;
			end
		end
	end

	assign quo = quo_s[QW];
endmodule

FILE: sv/rmq_unit_vec.sv
// Scales a vector of signed elements to unit length in Q2.30.
`timescale 1ns / 1ps
module rmq_unit_vec #(
	parameter int N  = 3,
	parameter int VW = 32
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic [N-1:0][VW-1:0]               v,
	output logic [N-1:0][rmq_pkg::UNIT_W-1:0]  o
);
	import rmq_pkg::*;

	localparam int PW   = $clog2(VW);
	localparam int SIDE = N * NORM_W + N + 1;

	logic [N-1:0][VW-1:0]     mag_s1;
	logic [N-1:0]             neg_s1;
	logic [VW-1:0]            all_or;
	logic [PW-1:0]            pos_c;
	logic [N-1:0][VW-1:0]     mag_s2;
	logic [N-1:0]             neg_s2;
	logic [PW-1:0]            pos_s2;
	logic                     zero_s2;
	logic [N-1:0][VW-1:0]     sh_c;
	logic [N-1:0][NORM_W-1:0] nm_s3;
	logic [N-1:0]             neg_s3;
	logic                     zero_s3;
	logic [N-1:0][UV_SQ_W-1:0] sq_s4;
	logic [UV_SUM_W-1:0]      sum_c;
	logic [UV_SUM_W-1:0]      sum_s5;
	logic [UV_LEN_W-1:0]      len;
	logic [N-1:0][NORM_W-1:0] nm_d;
	logic [N-1:0]             neg_d;
	logic                     zero_d;
	logic [N-1:0][UV_QW-1:0]  quo;
	logic [N-1:0]             neg_e;
	logic                     zero_e;
	logic [N-1:0][UNIT_W-1:0] res_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N; i++) begin
				neg_s1[i] <= v[i][VW-1];
				mag_s1[i] <= v[i][VW-1] ? (~v[i] + 1'b1) : v[i];
			end
		end
	end

	// The top bit of the OR of all magnitudes is the top bit of the largest one.
	always_comb begin
		all_or = '0;
		pos_c  = '0;
		for (int i = 0; i < N; i++) begin
			all_or = all_or | mag_s1[i];
		end
		for (int b = 0; b < VW; b++) begin
			if (all_or[b]) begin
				pos_c = PW'(b);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			pos_s2  <= pos_c;
			zero_s2 <= (all_or == '0);
		end
	end

	always_comb begin
		for (int i = 0; i < N; i++) begin
			if (pos_s2 >= PW'(NORM_POS)) begin
				sh_c[i] = mag_s2[i] >> (pos_s2 - PW'(NORM_POS));
			end else begin
				sh_c[i] = mag_s2[i] << (PW'(NORM_POS) - pos_s2);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N; i++) begin
				nm_s3[i] <= sh_c[i][NORM_W-1:0];
			end
			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N; i++) begin
				sq_s4[i] <= nm_s3[i] * nm_s3[i];
			end
		end
	end

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < N; i++) begin
			sum_c = sum_c + UV_SUM_W'(sq_s4[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s5 <= sum_c;
		end
	end

	rmq_isqrt #(.W(UV_SUM_W)) u_len (
		.clk  (clk),
		.en   (en),
		.rad  (sum_s5),
		.root (len)
	);

	rmq_delay #(.W(SIDE), .D(2 + UV_SUM_W / 2)) u_side_a (
		.clk (clk),
		.en  (en),
		.d   ({nm_s3, neg_s3, zero_s3}),
		.q   ({nm_d, neg_d, zero_d})
	);

	for (genvar i = 0; i < N; i++) begin : g_div
		rmq_div #(.NW(UV_NUM_W), .DW(UV_LEN_W), .QW(UV_QW)) u_div (
			.clk (clk),
			.en  (en),
			.num ({nm_d[i], {UNIT_FRAC{1'b0}}}),
			.den (len),
			.quo (quo[i])
		);
	end

	rmq_delay #(.W(N + 1), .D(UV_QW)) u_side_b (
		.clk (clk),
		.en  (en),
		.d   ({neg_d, zero_d}),
		.q   ({neg_e, zero_e})
	);

	// An all-zero vector stays zero; its divider output is meaningless.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N; i++) begin
				if (zero_e) begin
					res_s6[i] <= '0;
				end else if (neg_e[i]) begin
					res_s6[i] <= '0 - UNIT_W'(quo[i]);
				end else begin
					res_s6[i] <= UNIT_W'(quo[i]);
				end
			end
		end
	end

	assign o = res_s6;
endmodule
